// ===== sv/tcpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-pixel charge interpolation package
// Shared constants and the event status code type.
// ----------------------------------------------------------------------------
package tcpi_pkg;

    localparam int PITCH_BITS  = 8;
    localparam int ETA_BITS    = 16;
    localparam int FRAC_BITS   = 8;
    localparam int STATUS_BITS = 2;

    localparam logic [PITCH_BITS-1:0] PITCH_RESET = 8'd50;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_TWO_PIXEL = 2'd0,
        ST_SINGLE    = 2'd1,
        ST_EMPTY     = 2'd2
    } t_status;

endpackage

// ===== sv/two_pixel_charge_interpolation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-pixel charge interpolation
// Keeps the two highest-charge hits of an event and, on the last hit, emits
// the charge-weighted position, the eta ratio and the cluster status.
//
// Hits arrive on a valid/ready channel (i_hit_*, o_hit_ready). A hit that is
// not the last of its event only updates the running top-two state. The last
// hit starts the event evaluation, during which o_hit_ready is low. An empty
// event is resolved in S_EVAL and a single-hit event in S_CEN_T.
// A two-pixel event runs two divisions on one shared restoring divider of
// CHARGE_BITS+COLUMN_BITS+17 bits, one quotient bit per cycle.
// The result is held on the o_* outputs with o_res_valid until the receiver
// takes it with i_res_ready; a stalled receiver holds the block, and the next
// hit is accepted in the cycle after the result transfer.
// The pitch register is written on the i_cfg_* channel, which is always
// ready; it should be written only while the block is idle.
// Reset sets the pitch to 50 um and clears the running top-two state.
// ----------------------------------------------------------------------------
module two_pixel_charge_interpolation #(
    parameter int COLUMN_BITS = 10,
    parameter int CHARGE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tcpi_pkg::PITCH_BITS-1:0]     i_cfg_data,
    input  logic                                i_hit_valid,
    output logic                                o_hit_ready,
    input  logic [COLUMN_BITS-1:0]              i_hit_col,
    input  logic [CHARGE_BITS-1:0]              i_hit_charge,
    input  logic                                i_last_hit,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [COLUMN_BITS+15:0]             o_reco_pos,
    output logic [tcpi_pkg::ETA_BITS-1:0]       o_eta_value,
    output logic [COLUMN_BITS-1:0]              o_top_col,
    output logic [COLUMN_BITS-1:0]              o_second_col,
    output logic [tcpi_pkg::STATUS_BITS-1:0]    o_event_status
);
    import tcpi_pkg::*;

    localparam int CW     = COLUMN_BITS;
    localparam int QW     = CHARGE_BITS;
    localparam int RECO_W = CW + 16;
    localparam int CP_W   = CW + PITCH_BITS;
    localparam int PROD_W = QW + RECO_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int SUM_W  = QW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_CEN_T,
        S_CEN_S,
        S_MUL_T,
        S_MUL_S,
        S_DIV_R,
        S_WAIT_R,
        S_DIV_E,
        S_WAIT_E,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [PITCH_BITS-1:0] r_pitch;
    logic [QW-1:0]         r_top_q;
    logic [CW-1:0]         r_top_c;
    logic [QW-1:0]         r_sec_q;
    logic [CW-1:0]         r_sec_c;
    logic [RECO_W-1:0]     r_cen_t;
    logic [RECO_W-1:0]     r_cen_s;
    logic [ACC_W-1:0]      r_acc;
    logic [RECO_W-1:0]     r_reco;
    logic [SUM_W-1:0]      r_sum;

    logic [RECO_W-1:0]     r_out_reco;
    logic [ETA_BITS-1:0]   r_out_eta;
    logic [CW-1:0]         r_out_top;
    logic [CW-1:0]         r_out_sec;
    t_status               r_out_status;

    logic [QW-1:0]         n_top_q;
    logic [CW-1:0]         n_top_c;
    logic [QW-1:0]         n_sec_q;
    logic [CW-1:0]         n_sec_c;

    logic [CW-1:0]         cen_col;
    logic [CP_W-1:0]       cen_cp;
    logic [RECO_W-1:0]     cen_val;
    logic [QW-1:0]         mul_a;
    logic [RECO_W-1:0]     mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [QW-1:0]         right_q;

    logic                  div_start;
    logic [ACC_W-1:0]      div_num;
    logic                  div_done;
    logic [ACC_W-1:0]      div_quot;

    always_comb begin
        n_top_q = r_top_q;
        n_top_c = r_top_c;
        n_sec_q = r_sec_q;
        n_sec_c = r_sec_c;
        if (i_hit_charge > r_top_q) begin
            n_top_q = i_hit_charge;
            n_top_c = i_hit_col;
            n_sec_q = r_top_q;
            n_sec_c = r_top_c;
        end else if (i_hit_charge > r_sec_q) begin
            n_sec_q = i_hit_charge;
            n_sec_c = i_hit_col;
        end
    end

    always_comb begin
        cen_col = (r_state == S_CEN_S) ? r_sec_c : r_top_c;
        cen_cp  = CP_W'(cen_col) * CP_W'(r_pitch);
        cen_val = {cen_cp, 8'b0} + RECO_W'({r_pitch, 7'b0});
        mul_a   = (r_state == S_MUL_S) ? r_sec_q : r_top_q;
        mul_b   = (r_state == S_MUL_S) ? r_cen_s : r_cen_t;
        mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
        right_q = (r_sec_c > r_top_c) ? r_sec_q : r_top_q;
    end

    assign div_start = (r_state == S_DIV_R) || (r_state == S_DIV_E);
    assign div_num   = (r_state == S_DIV_E) ? ACC_W'({right_q, 16'b0}) : r_acc;

    tcpi_div #(
        .NUM_W (ACC_W),
        .DEN_W (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pitch <= PITCH_RESET;
            r_top_q <= '0;
            r_top_c <= '0;
            r_sec_q <= '0;
            r_sec_c <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_pitch <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_hit_valid) begin
                        r_top_q <= n_top_q;
                        r_top_c <= n_top_c;
                        r_sec_q <= n_sec_q;
                        r_sec_c <= n_sec_c;
                        if (i_last_hit) begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    r_sum <= SUM_W'(r_top_q) + SUM_W'(r_sec_q);
                    if (r_top_q == '0) begin
                        r_out_reco   <= '0;
                        r_out_eta    <= '0;
                        r_out_top    <= '0;
                        r_out_sec    <= '0;
                        r_out_status <= ST_EMPTY;
                        r_top_c      <= '0;
                        r_sec_c      <= '0;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_CEN_T;
                    end
                end
                S_CEN_T: begin
                    r_cen_t <= cen_val;
                    if (r_sec_q == '0) begin
                        r_out_reco   <= cen_val;
                        r_out_eta    <= '0;
                        r_out_top    <= r_top_c;
                        r_out_sec    <= '0;
                        r_out_status <= ST_SINGLE;
                        r_top_q      <= '0;
                        r_top_c      <= '0;
                        r_sec_c      <= '0;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_CEN_S;
                    end
                end
                S_CEN_S: begin
                    r_cen_s <= cen_val;
                    r_state <= S_MUL_T;
                end
                S_MUL_T: begin
                    r_acc   <= ACC_W'(mul_p);
                    r_state <= S_MUL_S;
                end
                S_MUL_S: begin
                    r_acc   <= r_acc + ACC_W'(mul_p);
                    r_state <= S_DIV_R;
                end
                S_DIV_R: begin
                    r_state <= S_WAIT_R;
                end
                S_WAIT_R: begin
                    if (div_done) begin
                        r_reco  <= div_quot[RECO_W-1:0];
                        r_state <= S_DIV_E;
                    end
                end
                S_DIV_E: begin
                    r_state <= S_WAIT_E;
                end
                S_WAIT_E: begin
                    if (div_done) begin
                        r_out_reco   <= r_reco;
                        r_out_eta    <= div_quot[ETA_BITS-1:0];
                        r_out_top    <= r_top_c;
                        r_out_sec    <= r_sec_c;
                        r_out_status <= ST_TWO_PIXEL;
                        r_top_q      <= '0;
                        r_top_c      <= '0;
                        r_sec_q      <= '0;
                        r_sec_c      <= '0;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_hit_ready    = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_OUT);
    assign o_reco_pos     = r_out_reco;
    assign o_eta_value    = r_out_eta;
    assign o_top_col      = r_out_top;
    assign o_second_col   = r_out_sec;
    assign o_event_status = r_out_status;

endmodule

// ===== sv/tcpi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-pixel charge interpolation divider
// Restoring unsigned divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcpi_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quot[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quot <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[NUM_W-2:0], ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== dv/two_pixel_charge_interpolation_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-pixel charge interpolation testbench
// Drives hit events through the valid/ready hit channel and predicts each
// event's cluster result. The prediction covers the running top-two ranking,
// the weighted position, eta and status. Every result transfer is checked
// against the oldest prediction. Several pixel pitches are used, the extremes
// among them. The directed events come first, then random events. Both the
// hit sender and the result receiver pause at random.
// ----------------------------------------------------------------------------
module two_pixel_charge_interpolation_tb;

    import tcpi_pkg::*;

    localparam int COLUMN_BITS   = 10;
    localparam int CHARGE_BITS   = 16;
    localparam int RECO_BITS     = COLUMN_BITS + 16;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 120;
    localparam int RANDOM_HITS   = 1950;
    localparam int NUM_PHASES    = 8;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [RECO_BITS-1:0]   reco;
        logic [ETA_BITS-1:0]    eta;
        logic [COLUMN_BITS-1:0] top_col;
        logic [COLUMN_BITS-1:0] second_col;
        t_status                status;
    } t_cluster;

    class cluster_scoreboard;
        logic [PITCH_BITS-1:0]  pitch;
        logic [CHARGE_BITS-1:0] top_q;
        logic [CHARGE_BITS-1:0] sec_q;
        logic [COLUMN_BITS-1:0] top_c;
        logic [COLUMN_BITS-1:0] sec_c;
        t_cluster               expected_clusters[$];
        int                     errors;
        int                     checked;
        int                     hits;
        int                     n_two;
        int                     n_single;
        int                     n_empty;

        function new();
            pitch = PITCH_RESET;
            clear_event();
        endfunction

        function void clear_event();
            top_q = '0;
            sec_q = '0;
            top_c = '0;
            sec_c = '0;
        endfunction

        function logic [63:0] centre(logic [COLUMN_BITS-1:0] col);
            return 64'(col) * 64'(pitch) * 64'd256 + 64'(pitch) * 64'd128;
        endfunction

        function void note_hit(logic [COLUMN_BITS-1:0] col, logic [CHARGE_BITS-1:0] chg,
                               logic last);
            t_cluster    res;
            logic [63:0] sum;
            logic [63:0] right;
            hits++;
            if (chg > top_q) begin
                sec_q = top_q;
                sec_c = top_c;
                top_q = chg;
                top_c = col;
            end else if (chg > sec_q) begin
                sec_q = chg;
                sec_c = col;
            end
            if (!last) return;
            res.reco = '0;
            res.eta = '0;
            res.top_col = '0;
            res.second_col = '0;
            if (top_q == 0) begin
                res.status = ST_EMPTY;
                n_empty++;
            end else if (sec_q == 0) begin
                res.status = ST_SINGLE;
                res.top_col = top_c;
                res.reco = RECO_BITS'(centre(top_c));
                n_single++;
            end else begin
                sum = 64'(top_q) + 64'(sec_q);
                right = (sec_c > top_c) ? 64'(sec_q) : 64'(top_q);
                res.status = ST_TWO_PIXEL;
                res.top_col = top_c;
                res.second_col = sec_c;
                res.reco = RECO_BITS'((64'(top_q) * centre(top_c)
                                       + 64'(sec_q) * centre(sec_c)) / sum);
                res.eta = ETA_BITS'((right << 16) / sum);
                n_two++;
            end
            expected_clusters.push_back(res);
            clear_event();
        endfunction

        function void check_result(t_cluster got);
            t_cluster exp;
            checked++;
            if (expected_clusters.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result reco=%0d eta=%0d top=%0d second=%0d status=%0d",
                             $time, got.reco, got.eta, got.top_col, got.second_col, got.status);
                return;
            end
            exp = expected_clusters.pop_front();
            if (got.reco !== exp.reco || got.eta !== exp.eta || got.top_col !== exp.top_col ||
                got.second_col !== exp.second_col || got.status !== exp.status) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result mismatch, expected reco=%0d eta=%0d top=%0d second=%0d status=%0d, got reco=%0d eta=%0d top=%0d second=%0d status=%0d",
                             $time, exp.reco, exp.eta, exp.top_col, exp.second_col, exp.status,
                             got.reco, got.eta, got.top_col, got.second_col, got.status);
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [PITCH_BITS-1:0]   i_cfg_data;
    logic                    i_hit_valid;
    logic                    o_hit_ready;
    logic [COLUMN_BITS-1:0]  i_hit_col;
    logic [CHARGE_BITS-1:0]  i_hit_charge;
    logic                    i_last_hit;
    logic                    o_res_valid;
    logic                    i_res_ready;
    logic [RECO_BITS-1:0]    o_reco_pos;
    logic [ETA_BITS-1:0]     o_eta_value;
    logic [COLUMN_BITS-1:0]  o_top_col;
    logic [COLUMN_BITS-1:0]  o_second_col;
    logic [STATUS_BITS-1:0]  o_event_status;

    cluster_scoreboard sb = new();
    bit  quiet = 1'b0;
    int  hits_sent = 0;
    int  events_sent = 0;
    int  pitches_used = 1;
    int  cycle_count = 0;
    int  stall_left = 0;

    two_pixel_charge_interpolation #(
        .COLUMN_BITS (COLUMN_BITS),
        .CHARGE_BITS (CHARGE_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_hit_valid    (i_hit_valid),
        .o_hit_ready    (o_hit_ready),
        .i_hit_col      (i_hit_col),
        .i_hit_charge   (i_hit_charge),
        .i_last_hit     (i_last_hit),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_reco_pos     (o_reco_pos),
        .o_eta_value    (o_eta_value),
        .o_top_col      (o_top_col),
        .o_second_col   (o_second_col),
        .o_event_status (o_event_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_cluster got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.pitch = i_cfg_data;
            if (i_hit_valid && o_hit_ready)
                sb.note_hit(i_hit_col, i_hit_charge, i_last_hit);
            if (o_res_valid && i_res_ready) begin
                got.reco = o_reco_pos;
                got.eta = o_eta_value;
                got.top_col = o_top_col;
                got.second_col = o_second_col;
                got.status = t_status'(o_event_status);
                sb.check_result(got);
            end
        end
    end

    initial begin
        i_res_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 3);
            if (stall_left > 0) begin
                i_res_ready = 1'b0;
                stall_left--;
            end else begin
                i_res_ready = 1'b1;
            end
        end
    end

    task automatic pause_hits(input int n);
        @(negedge i_clk);
        i_hit_valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_hit(input logic [COLUMN_BITS-1:0] col,
                            input logic [CHARGE_BITS-1:0] chg, input logic last);
        @(negedge i_clk);
        i_hit_valid = 1'b1;
        i_hit_col = col;
        i_hit_charge = chg;
        i_last_hit = last;
        do @(posedge i_clk); while (!o_hit_ready);
        hits_sent++;
        if (last) events_sent++;
        if (!quiet && $urandom_range(0, 4) == 0)
            pause_hits($urandom_range(1, 3));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_hit_valid = 1'b0;
        while (sb.expected_clusters.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pitch(input logic [PITCH_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        pitches_used++;
    endtask

    function automatic logic [CHARGE_BITS-1:0] rand_charge();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return CHARGE_BITS'($urandom_range(1, 255));
            default: return CHARGE_BITS'($urandom);
        endcase
    endfunction

    task automatic random_event();
        int                     kind;
        int                     len;
        logic [COLUMN_BITS-1:0] base;
        logic [COLUMN_BITS-1:0] col;
        logic [CHARGE_BITS-1:0] chg;
        kind = $urandom_range(0, 19);
        case ($urandom_range(0, 5))
            0: base = '0;
            1: base = '1;
            default: base = COLUMN_BITS'($urandom);
        endcase
        chg = rand_charge();
        if (kind < 15) len = $urandom_range(1, 5);
        else if (kind < 17) len = $urandom_range(6, 20);
        else len = $urandom_range(1, 4);
        for (int j = 0; j < len; j++) begin
            if (kind < 15) begin
                col = (j == 0) ? base : base + COLUMN_BITS'($urandom_range(0, 2)) - 1'b1;
                chg = rand_charge();
            end else if (kind < 17) begin
                col = COLUMN_BITS'($urandom);
                chg = ($urandom_range(0, 2) == 0) ? '0 : rand_charge();
            end else if (kind < 19) begin
                col = COLUMN_BITS'($urandom);
                chg = '0;
            end else begin
                col = base + COLUMN_BITS'($urandom_range(0, 1));
            end
            send_hit(col, chg, j == len - 1);
        end
    endtask

    initial begin
        logic [PITCH_BITS-1:0] pitch;
        int                    target;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_hit_valid = 1'b0;
        i_hit_col = '0;
        i_hit_charge = '0;
        i_last_hit = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed events at the reset pitch.
        send_hit(10'd5, 16'd0, 1'b1);
        send_hit(10'd1023, 16'd0, 1'b0);
        send_hit(10'd0, 16'd0, 1'b1);
        send_hit(10'd1023, 16'hFFFF, 1'b1);
        send_hit(10'd0, 16'd1, 1'b1);
        send_hit(10'd10, 16'd40000, 1'b0);
        send_hit(10'd11, 16'd20000, 1'b1);
        send_hit(10'd500, 16'd100, 1'b0);
        send_hit(10'd499, 16'd30000, 1'b1);
        send_hit(10'd7, 16'd1000, 1'b0);
        send_hit(10'd7, 16'd2000, 1'b1);
        send_hit(10'd3, 16'd500, 1'b0);
        send_hit(10'd4, 16'd500, 1'b0);
        send_hit(10'd5, 16'd500, 1'b1);
        send_hit(10'd1, 16'd100, 1'b0);
        send_hit(10'd2, 16'd200, 1'b0);
        send_hit(10'd3, 16'd300, 1'b1);
        send_hit(10'd1023, 16'hFFFF, 1'b0);
        send_hit(10'd0, 16'hFFFF, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: pitch = '1;
                1: pitch = 8'd1;
                2: pitch = '0;
                default: pitch = PITCH_BITS'($urandom_range(1, 255));
            endcase
            write_pitch(pitch);
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            target = hits_sent + RANDOM_HITS / NUM_PHASES;
            while (hits_sent < target) begin
                random_event();
                if ($urandom_range(0, 59) == 0) drain();
            end
            drain();
        end

        $display("Covered %0d hits in %0d events over %0d pitch settings, with idle and stall bursts.",
                 hits_sent, events_sent, pitches_used);
        $display("Clusters: %0d two-pixel, %0d single-hit, %0d empty; %0d results checked.",
                 sb.n_two, sb.n_single, sb.n_empty, sb.checked);
        if (sb.expected_clusters.size() != 0)
            $display("%0d expected results never arrived", sb.expected_clusters.size());
        if (sb.errors == 0 && sb.expected_clusters.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== two_pixel_charge_interpolation.f =====
sv/tcpi_pkg.sv
sv/tcpi_div.sv
sv/two_pixel_charge_interpolation.sv
dv/two_pixel_charge_interpolation_tb.sv
